@@ hdl/editable_mmss_countdown_timer_assert.svh @@
// ----------------------------------------------------------------------------
// editable_mmss_countdown_timer_assert.svh
// assertion macros for the mm:ss countdown timer, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef EDITABLE_MMSS_COUNTDOWN_TIMER_ASSERT_SVH
`define EDITABLE_MMSS_COUNTDOWN_TIMER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked outside reset
`define EMCT_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed: implication");

// next-cycle implication, checked outside reset
`define EMCT_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed: next-cycle implication");

`else

`define EMCT_ASSERT_IMPLIES(label, clk, rst, cond, prop)
`define EMCT_ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

@@ hdl/emct_pkg.sv @@
// ----------------------------------------------------------------------------
// emct_pkg
// shared types and constants for the mm:ss countdown timer
// ----------------------------------------------------------------------------
package emct_pkg;

  // event kinds carried on the input tuser
  typedef enum logic [2:0] {
    FUNC_TICK  = 3'd0,
    FUNC_DIGIT = 3'd1,
    FUNC_RIGHT = 3'd2,
    FUNC_LEFT  = 3'd3,
    FUNC_START = 3'd4
  } func_t;

  // display positions of the edit cursor
  localparam logic [2:0] POS_MIN_TENS  = 3'd0;
  localparam logic [2:0] POS_MIN_UNITS = 3'd1;
  localparam logic [2:0] POS_COLON     = 3'd2;
  localparam logic [2:0] POS_SEC_TENS  = 3'd3;
  localparam logic [2:0] POS_SEC_UNITS = 3'd4;

  localparam logic [3:0] TENS_MAX  = 4'd5;
  localparam logic [3:0] UNITS_MAX = 4'd9;

  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 24;

  typedef struct packed {
    logic [2:0] min_tens;
    logic [3:0] min_units;
    logic [2:0] sec_tens;
    logic [3:0] sec_units;
    logic [2:0] cursor;
    logic       running;
  } timer_state_t;

  localparam timer_state_t TIMER_RESET = '{
    min_tens:  3'd0,
    min_units: 4'd0,
    sec_tens:  3'd0,
    sec_units: 4'd0,
    cursor:    3'd0,
    running:   1'b0
  };

  function automatic logic time_zero(input timer_state_t s);
    return (s.min_tens == 3'd0) && (s.min_units == 4'd0) &&
           (s.sec_tens == 3'd0) && (s.sec_units == 4'd0);
  endfunction

endpackage

@@ hdl/emct_next.sv @@
// ----------------------------------------------------------------------------
// emct_next
// next timer state for one event: editing, start/stop and countdown
// ----------------------------------------------------------------------------
module emct_next (
  input  emct_pkg::timer_state_t state,
  input  logic [2:0]             func,
  input  logic [3:0]             digit,
  output emct_pkg::timer_state_t state_next,
  output logic                   expired
);
  import emct_pkg::*;

  timer_state_t dec;

  // decrement with borrows, only used when the time is nonzero
  always_comb begin
    dec = state;
    if (state.sec_units != 4'd0) begin
      dec.sec_units = state.sec_units - 4'd1;
    end else begin
      dec.sec_units = UNITS_MAX;
      if (state.sec_tens != 3'd0) begin
        dec.sec_tens = state.sec_tens - 3'd1;
      end else begin
        dec.sec_tens = TENS_MAX[2:0];
        if (state.min_units != 4'd0) begin
          dec.min_units = state.min_units - 4'd1;
        end else begin
          dec.min_units = UNITS_MAX;
          dec.min_tens  = state.min_tens - 3'd1;
        end
      end
    end
  end

  always_comb begin
    timer_state_t ticked;
    state_next = state;
    expired    = 1'b0;
    ticked     = time_zero(state) ? state : dec;
    if (state.running) begin
      case (func_t'(func))
        FUNC_TICK: begin
          state_next = ticked;
          if (time_zero(ticked)) begin
            state_next.running = 1'b0;
            state_next.cursor  = POS_MIN_TENS;
            expired            = 1'b1;
          end
        end
        FUNC_START: begin
          state_next = TIMER_RESET;
        end
        default: begin
          state_next = state;
        end
      endcase
    end else begin
      case (func_t'(func))
        FUNC_DIGIT: begin
          if (digit <= UNITS_MAX) begin
            case (state.cursor)
              POS_MIN_TENS:  if (digit <= TENS_MAX) state_next.min_tens = digit[2:0];
              POS_MIN_UNITS: state_next.min_units = digit;
              POS_SEC_TENS:  if (digit <= TENS_MAX) state_next.sec_tens = digit[2:0];
              POS_SEC_UNITS: state_next.sec_units = digit;
              default:       state_next = state;
            endcase
          end
        end
        FUNC_RIGHT: begin
          state_next.cursor = (state.cursor >= POS_SEC_UNITS) ? POS_MIN_TENS
                                                              : state.cursor + 3'd1;
        end
        FUNC_LEFT: begin
          state_next.cursor = (state.cursor == POS_MIN_TENS || state.cursor > POS_SEC_UNITS)
                              ? POS_SEC_UNITS : state.cursor - 3'd1;
        end
        FUNC_START: begin
          if (!time_zero(state)) state_next.running = 1'b1;
        end
        default: begin
          state_next = state;
        end
      endcase
    end
  end

endmodule

@@ hdl/editable_mmss_countdown_timer.sv @@
// ----------------------------------------------------------------------------
// editable_mmss_countdown_timer
// kitchen-style mm:ss countdown timer with an editable four-digit display
// ----------------------------------------------------------------------------
// usage
//   input channel (s_*): one event per item, kind on s_tuser, key digit on
//   s_tdata; tick items come from an external one-second strobe
//   output channel (m_*): exactly one item per event, the display state
//   after that event plus an expiry flag set only by the final tick
// timing
//   an accepted item passes one input register, then the next-state logic
//   feeding the result and state registers; throughput one item per cycle
//   while m_tready is high; the borrow chain over four bcd digits is the
//   only logic of any depth between the two registers
// reset
//   synchronous rst clears the time to 00:00, the cursor to position 0,
//   the running flag, and empties both register stages
// back-pressure
//   while m_tready is low the result register holds and one more item is
//   taken into the input register; s_tready drops only when both are full
// ----------------------------------------------------------------------------
`include "editable_mmss_countdown_timer_assert.svh"

module editable_mmss_countdown_timer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [3:0] digit, [7:4] zero
  input  logic [emct_pkg::IN_DATA_W-1:0]      s_tdata,
  // [2:0] func
  input  logic [emct_pkg::IN_USER_W-1:0]      s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [2:0] minute_tens, [6:3] minute_units, [9:7] second_tens,
  // [13:10] second_units, [16:14] cursor_pos, [17] is_running,
  // [18] expired, [23:19] zero
  output logic [emct_pkg::OUT_DATA_W-1:0]     m_tdata
);
  import emct_pkg::*;

  // input stage
  logic       in_valid;
  logic [2:0] in_func;
  logic [3:0] in_digit;

  // timer state and result stage
  timer_state_t state;
  timer_state_t state_next;
  logic         expired_next;
  logic         out_valid;
  logic [OUT_DATA_W-1:0] out_data;

  logic advance;

  // the input item moves on whenever the result register is free or draining
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  emct_next u_next (
    .state      (state),
    .func       (in_func),
    .digit      (in_digit),
    .state_next (state_next),
    .expired    (expired_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      state     <= TIMER_RESET;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        // state only moves when the item's result is written
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_func  <= s_tuser;
      in_digit <= s_tdata[3:0];
    end
    if (advance) begin
      out_data <= {5'd0, expired_next, state_next.running, state_next.cursor,
                   state_next.sec_units, state_next.sec_tens,
                   state_next.min_units, state_next.min_tens};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  // a running countdown never shows 00:00
  `EMCT_ASSERT_IMPLIES(a_run_nonzero, clk, rst, state.running, !time_zero(state))

  // the cursor stays on the five display positions
  `EMCT_ASSERT_IMPLIES(a_cursor_range, clk, rst, 1'b1, state.cursor <= POS_SEC_UNITS)

  // an expiry result shows a stopped timer at 00:00 with the cursor home
  `EMCT_ASSERT_IMPLIES(a_expired_home, clk, rst, out_valid && out_data[18],
    !out_data[17] && out_data[16:14] == POS_MIN_TENS && out_data[13:0] == 14'd0)

  // with both stages full and the output stalled, no item is taken
  `EMCT_ASSERT_IMPLIES(a_full_stall, clk, rst, in_valid && out_valid && !m_tready,
    !s_tready)

  // a consumed result with nothing behind it leaves the output empty
  `EMCT_ASSERT_NEXT(a_drain, clk, rst, out_valid && m_tready && !in_valid, !out_valid)

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the mm:ss countdown timer: a directed opening, then
// random edit-and-countdown sessions under several idle and stall mixes, each
// result item checked field by field against an in-bench timer model
// ----------------------------------------------------------------------------
module testbench;
  import emct_pkg::*;

  // event kinds outside the decoded set, which the timer must ignore
  localparam logic [2:0] FUNC_UNUSED_5 = 3'd5;
  localparam logic [2:0] FUNC_UNUSED_6 = 3'd6;
  localparam logic [2:0] FUNC_UNUSED_7 = 3'd7;

  // kinds that may be slipped into a running countdown without stopping it
  localparam logic [2:0] STRAY_KINDS [6] = '{FUNC_DIGIT, FUNC_RIGHT, FUNC_LEFT,
                                             FUNC_UNUSED_5, FUNC_UNUSED_6, FUNC_UNUSED_7};

  localparam int unsigned HOLD_CYCLES = 80;
  // sessions run past the phase quota, so each phase can end some items over it
  localparam int unsigned PHASE_ITEMS = 200;

  // display as the timer should show it after one event
  typedef struct {
    logic [2:0] min_tens;
    logic [3:0] min_units;
    logic [2:0] sec_tens;
    logic [3:0] sec_units;
    logic [2:0] cursor;
    logic       running;
    logic       expired;
  } display_t;

  class timer_scoreboard;
    logic [3:0]  digits [4];   // minute tens, minute units, second tens, second units
    logic [2:0]  cursor;
    logic        running;
    display_t    due_displays [$];
    int unsigned errors;
    int unsigned checked;
    int unsigned expiries;
    int unsigned aborts;

    function new();
      digits   = '{4'd0, 4'd0, 4'd0, 4'd0};
      cursor   = POS_MIN_TENS;
      running  = 1'b0;
      errors   = 0;
      checked  = 0;
      expiries = 0;
      aborts   = 0;
    endfunction

    function bit at_zero();
      return (digits[0] | digits[1] | digits[2] | digits[3]) == 4'd0;
    endfunction

    function int unsigned seconds_left();
      return (digits[0] * 10 + digits[1]) * 60 + digits[2] * 10 + digits[3];
    endfunction

    // one second off, borrowing into tens (wrap to 5) and units (wrap to 9)
    function void count_down();
      for (int i = 3; i >= 0; i--) begin
        if (digits[i] != 4'd0) begin
          digits[i] = digits[i] - 4'd1;
          return;
        end
        digits[i] = (i % 2 == 0) ? TENS_MAX : UNITS_MAX;
      end
    endfunction

    // advance the timer by one accepted event and queue the display it leaves
    function void note_event(logic [2:0] f, logic [3:0] d);
      display_t shown;
      logic     tens;
      shown.expired = 1'b0;
      if (running) begin
        if (f == FUNC_TICK) begin
          if (!at_zero()) count_down();
          if (at_zero()) begin
            running       = 1'b0;
            cursor        = POS_MIN_TENS;
            shown.expired = 1'b1;
            expiries++;
          end
        end else if (f == FUNC_START) begin
          digits  = '{4'd0, 4'd0, 4'd0, 4'd0};
          cursor  = POS_MIN_TENS;
          running = 1'b0;
          aborts++;
        end
      end else begin
        case (f)
          FUNC_DIGIT: begin
            if (cursor != POS_COLON && cursor <= POS_SEC_UNITS && d <= UNITS_MAX) begin
              tens = (cursor == POS_MIN_TENS) || (cursor == POS_SEC_TENS);
              if (!(tens && d > TENS_MAX))
                digits[2'((cursor < POS_COLON) ? cursor : cursor - 3'd1)] = d;
            end
          end
          FUNC_RIGHT: begin
            cursor = (cursor >= POS_SEC_UNITS) ? POS_MIN_TENS : cursor + 3'd1;
          end
          FUNC_LEFT: begin
            cursor = (cursor == POS_MIN_TENS || cursor > POS_SEC_UNITS) ?
                     POS_SEC_UNITS : cursor - 3'd1;
          end
          FUNC_START: begin
            if (!at_zero()) running = 1'b1;
          end
          default: ;
        endcase
      end
      shown.min_tens  = digits[0][2:0];
      shown.min_units = digits[1];
      shown.sec_tens  = digits[2][2:0];
      shown.sec_units = digits[3];
      shown.cursor    = cursor;
      shown.running   = running;
      due_displays.push_back(shown);
    endfunction

    function void compare(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $error("%s: expected %0d, got %0d", name, want, got);
      end
    endfunction

    function void check_display(logic [OUT_DATA_W-1:0] word);
      display_t want;
      if (due_displays.size() == 0) begin
        errors++;
        $error("result item with no event waiting: %h", word);
        return;
      end
      want = due_displays.pop_front();
      checked++;
      compare("minute_tens",  want.min_tens,  word[2:0]);
      compare("minute_units", want.min_units, word[6:3]);
      compare("second_tens",  want.sec_tens,  word[9:7]);
      compare("second_units", want.sec_units, word[13:10]);
      compare("cursor_pos",   want.cursor,    word[16:14]);
      compare("is_running",   want.running,   word[17]);
      compare("expired",      want.expired,   word[18]);
      compare("padding",      0,              word[23:19]);
    endfunction
  endclass

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;   // [3:0] digit, [7:4] zero
  logic [IN_USER_W-1:0]  s_tuser  = '0;   // [2:0] func
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;         // display fields, see check_display

  timer_scoreboard sb;
  int unsigned     idle_pct    = 0;
  int unsigned     stall_pct   = 0;
  int unsigned     hold_reqs   = 0;
  int unsigned     hold_served = 0;
  int unsigned     hold_left   = 0;
  int unsigned     sent_items  = 0;
  int unsigned     idle_plan [4]  = '{0, 50, 0, 22};
  int unsigned     stall_plan [4] = '{0, 0, 50, 22};

  editable_mmss_countdown_timer DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // result side: check accepted items, then pick next cycle's ready
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_display(m_tdata);
    if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_reqs) begin
      // long hold-off so the pipeline fills and the input stalls
      m_tready    <= 1'b0;
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_served + 1;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #5000000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [3:0] any_digit();
    return 4'($urandom_range(15));
  endfunction

  // offer one event, possibly after a random gap, and wait for acceptance
  task automatic send_event(input logic [2:0] f, input logic [3:0] d);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= f;
    s_tdata  <= {4'd0, d};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_event(f, d);
    sent_items++;
  endtask

  // stop offering until every queued display has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.due_displays.size() != 0) @(posedge clk);
  endtask

  // walk the cursor, mostly the short way round
  task automatic move_cursor_to(input logic [2:0] pos);
    int unsigned ahead;
    while (sb.cursor != pos) begin
      ahead = (int'(pos) - int'(sb.cursor) + 5) % 5;
      if ((ahead <= 2) ^ ($urandom_range(3) == 0)) send_event(FUNC_RIGHT, any_digit());
      else send_event(FUNC_LEFT, any_digit());
    end
  endtask

  task automatic type_key(input logic [2:0] pos, input logic [3:0] value);
    logic tens;
    move_cursor_to(pos);
    tens = (pos == POS_MIN_TENS) || (pos == POS_SEC_TENS);
    // now and then a key that must be refused first
    if ($urandom_range(9) == 0)
      send_event(FUNC_DIGIT, tens ? 4'($urandom_range(15, 6)) : 4'($urandom_range(15, 10)));
    send_event(FUNC_DIGIT, value);
  endtask

  // set a time, start it, tick it down to expiry or abort part way, or random events
  task automatic timer_session();
    logic [3:0]  want [4];
    logic [2:0]  spots [4];
    int unsigned first;
    int unsigned ticks;
    int unsigned r;
    spots = '{POS_MIN_TENS, POS_MIN_UNITS, POS_SEC_TENS, POS_SEC_UNITS};
    if ($urandom_range(99) < 12) begin
      repeat ($urandom_range(6, 1)) send_event(3'($urandom_range(7)), any_digit());
      return;
    end
    if (sb.running) send_event(FUNC_START, any_digit());
    // mostly short times so that most countdowns reach 00:00
    r       = $urandom_range(3);
    want[0] = (r == 0) ? 4'($urandom_range(5)) : 4'd0;
    r       = $urandom_range(3);
    want[1] = (r < 2) ? 4'd0 : (r == 2) ? 4'd1 : 4'($urandom_range(9));
    want[2] = 4'($urandom_range(5));
    want[3] = 4'($urandom_range(9));
    first   = $urandom_range(3);
    for (int k = 0; k < 4; k++) type_key(spots[(first + k) % 4], want[(first + k) % 4]);
    if ($urandom_range(9) == 0) begin
      move_cursor_to(POS_COLON);
      send_event(FUNC_DIGIT, any_digit());
    end
    send_event(FUNC_START, any_digit());
    ticks = sb.seconds_left();
    if (ticks > 150 || $urandom_range(9) == 0)
      ticks = $urandom_range((ticks < 40) ? ticks : 40);
    while (sb.running && ticks != 0) begin
      if ($urandom_range(99) < 8) begin
        send_event(STRAY_KINDS[$urandom_range(5)], any_digit());
      end else begin
        send_event(FUNC_TICK, any_digit());
        ticks--;
      end
    end
    if (sb.running) send_event(FUNC_START, any_digit());
  endtask

  initial begin
    int unsigned phase_end;
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed opening
    send_event(FUNC_TICK, 4'd0);        // tick while idle
    send_event(FUNC_START, 4'd0);       // start at 00:00 refused
    send_event(FUNC_UNUSED_5, 4'd15);   // unused kind, digit field at its top
    send_event(FUNC_LEFT, 4'd0);        // wrap 0 -> 4
    send_event(FUNC_DIGIT, 4'd10);      // not a digit
    send_event(FUNC_LEFT, 4'd0);
    send_event(FUNC_DIGIT, 4'd6);       // too big for a tens place
    send_event(FUNC_LEFT, 4'd0);
    send_event(FUNC_DIGIT, 4'd7);       // typed on the colon
    send_event(FUNC_LEFT, 4'd0);
    send_event(FUNC_DIGIT, 4'd9);       // 09:00
    send_event(FUNC_LEFT, 4'd0);
    send_event(FUNC_DIGIT, 4'd6);
    send_event(FUNC_DIGIT, 4'd5);       // 59:00
    send_event(FUNC_RIGHT, 4'd0);
    send_event(FUNC_DIGIT, 4'd0);       // 50:00
    send_event(FUNC_START, 4'd0);
    send_event(FUNC_TICK, 4'd0);        // borrow through every digit: 49:59
    send_event(FUNC_DIGIT, 4'd3);       // keys ignored while running
    send_event(FUNC_RIGHT, 4'd0);
    send_event(FUNC_START, 4'd0);       // abort clears to 00:00
    send_event(FUNC_LEFT, 4'd0);
    send_event(FUNC_DIGIT, 4'd1);       // 00:01
    send_event(FUNC_START, 4'd0);
    send_event(FUNC_TICK, 4'd0);        // expiry, cursor back home
    drain();

    // random sessions under each idle / stall mix
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = idle_plan[phase];
      stall_pct <= stall_plan[phase];
      if (phase == 0) hold_reqs <= hold_reqs + 1;
      phase_end = sent_items + PHASE_ITEMS;
      while (sent_items < phase_end) timer_session();
      drain();
    end

    repeat (8) @(posedge clk);
    $display("%0d events sent, %0d result items checked, %0d expiries, %0d aborted countdowns",
             sent_items, sb.checked, sb.expiries, sb.aborts);
    $display("all event kinds, rejected keys, cursor wraps and borrows under idle and stall");
    if (sb.errors == 0 && sb.due_displays.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
